/* sv/sgbs_pkg.sv */
`timescale 1ns / 1ps
// shared constants and types for the staggered grid bilinear sampler
package sgbs_pkg;

  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned FRAC_W      = FRAC_BITS + 1;
  localparam int unsigned RECIP_W     = 24;
  localparam int unsigned POINT_W     = 32;
  localparam int unsigned SIZE_REG_W  = 9;
  localparam int unsigned CELL_IDX_W  = 8;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 24;
  localparam int unsigned PROD_W      = POINT_W + RECIP_W;
  localparam int unsigned POS_W       = PROD_W - FRAC_BITS + 1;
  localparam int unsigned CMP_W       = 13;

  localparam logic [FRAC_W-1:0] ONE_Q16 = FRAC_W'(1 << FRAC_BITS);
  localparam int unsigned ROUND_HALF    = 1 << (FRAC_BITS - 1);

  localparam logic [RECIP_W-1:0]    RECIP_RST  = RECIP_W'(65536);
  localparam logic [FRAC_W-1:0]     OFFSET_RST = '0;
  localparam logic [SIZE_REG_W-1:0] SIZE_RST   = SIZE_REG_W'(256);

  localparam int unsigned DEF_MAX_COLS   = 256;
  localparam int unsigned DEF_MAX_ROWS   = 256;
  localparam int unsigned DEF_VALUE_BITS = 32;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RECIP_W   = 3'd0,
    REG_RECIP_H   = 3'd1,
    REG_OFFSET_X  = 3'd2,
    REG_OFFSET_Y  = 3'd3,
    REG_COLS      = 3'd4,
    REG_ROWS      = 3'd5
  } cfg_reg_e;

endpackage

/* sv/sgbs_if.sv */
`timescale 1ns / 1ps
// channel interfaces for queries, results and register writes
interface sgbs_in_if
  import sgbs_pkg::*;
#(
  parameter int unsigned VALUE_BITS = DEF_VALUE_BITS
);
  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic [CELL_IDX_W-1:0]        cell_col;
  logic [CELL_IDX_W-1:0]        cell_row;
  logic signed [VALUE_BITS-1:0] cell_value;
  logic [POINT_W-1:0]           point_x;
  logic [POINT_W-1:0]           point_y;

  modport source (output valid, opcode, cell_col, cell_row, cell_value, point_x, point_y,
                  input ready);
  modport sink (input valid, opcode, cell_col, cell_row, cell_value, point_x, point_y,
                output ready);
endinterface

interface sgbs_out_if
  import sgbs_pkg::*;
#(
  parameter int unsigned VALUE_BITS = DEF_VALUE_BITS
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] sample_value;

  modport source (output valid, sample_value, input ready);
  modport sink (input valid, sample_value, output ready);
endinterface

interface sgbs_cfg_if
  import sgbs_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* sv/sgbs_locate.sv */
`timescale 1ns / 1ps
// two stage grid position unit for one axis: scale, offset, saturate, split
module sgbs_locate
  import sgbs_pkg::*;
#(
  parameter int unsigned MAX_SIZE = DEF_MAX_COLS,
  localparam int unsigned IW = (MAX_SIZE > 2) ? $clog2(MAX_SIZE) : 1,
  localparam int unsigned SW = $clog2(MAX_SIZE + 1)
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [POINT_W-1:0] point_i,
  input  logic [RECIP_W-1:0] recip_i,
  input  logic [FRAC_W-1:0]  offset_i,
  input  logic [SW-1:0]      size_i,
  output logic [IW-1:0]      cell_o,
  output logic [FRAC_W-1:0]  frac_o
);

  logic [PROD_W-1:0] prod_q;
  logic [POS_W-1:0]  pos, top, pos_sat;
  logic [IW-1:0]     cell_raw, cell_d, cell_q;
  logic [FRAC_W-1:0] frac_d, frac_q;
  logic              last;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= PROD_W'(point_i) * PROD_W'(recip_i);
    end
  end

  always_comb begin
    pos      = POS_W'(prod_q[PROD_W-1:FRAC_BITS]) + POS_W'(offset_i);
    top      = POS_W'(size_i - SW'(1)) << FRAC_BITS;
    pos_sat  = (pos > top) ? top : pos;
    cell_raw = pos_sat[FRAC_BITS +: IW];
    last     = (pos_sat == top);
    cell_d   = last ? (cell_raw - IW'(1)) : cell_raw;
    frac_d   = last ? ONE_Q16 : {1'b0, pos_sat[FRAC_BITS-1:0]};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
      frac_q <= frac_d;
    end
  end

  assign cell_o = cell_q;
  assign frac_o = frac_q;

endmodule

/* sv/sgbs_bank.sv */
`timescale 1ns / 1ps
// one grid bank: single write port, registered read port
module sgbs_bank #(
  parameter int unsigned DEPTH = 16384,
  parameter int unsigned VALUE_BITS = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic                  we_i,
  input  logic [AW-1:0]         waddr_i,
  input  logic [VALUE_BITS-1:0] wdata_i,
  input  logic [AW-1:0]         raddr_i,
  output logic [VALUE_BITS-1:0] rdata_o
);

  logic [VALUE_BITS-1:0] mem [DEPTH];
  logic [VALUE_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[waddr_i] <= wdata_i;
      end
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/sgbs_lerp.sv */
`timescale 1ns / 1ps
// two stage rounded linear blend a + (b - a) * f
module sgbs_lerp
  import sgbs_pkg::*;
#(
  parameter int unsigned VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic signed [VALUE_BITS-1:0] a_i,
  input  logic signed [VALUE_BITS-1:0] b_i,
  input  logic [FRAC_W-1:0]            f_i,
  output logic signed [VALUE_BITS-1:0] y_o
);

  localparam int unsigned DW = VALUE_BITS + 1;
  localparam int unsigned PW = DW + FRAC_W + 1;
  localparam int unsigned SW = PW - FRAC_BITS;

  logic signed [DW-1:0]         diff;
  logic signed [PW-1:0]         prod_d, prod_q;
  logic signed [VALUE_BITS-1:0] a_q, y_q;
  logic signed [PW-1:0]         rounded;
  logic signed [SW-1:0]         sum;

  always_comb begin
    diff   = DW'(b_i) - DW'(a_i);
    prod_d = PW'(diff) * PW'(signed'({1'b0, f_i}));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      a_q    <= a_i;
    end
  end

  always_comb begin
    rounded = prod_q + PW'(ROUND_HALF);
    sum     = SW'(rounded >>> FRAC_BITS) + SW'(a_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      y_q <= sum[VALUE_BITS-1:0];
    end
  end

  assign y_o = y_q;

endmodule

/* sv/staggered_grid_bilinear_sampler.sv */
`timescale 1ns / 1ps
// top level of the staggered grid bilinear sampler
//
// in_i carries one transaction per cell write or per sample query; opcode
// selects which. A write stores cell_value at (cell_col, cell_row) and gives
// no result. A query turns point_x/point_y into grid units and returns the
// bilinear blend of the four surrounding cells on out_o as sample_value.
// cfg_i writes the scale, offset and size registers by index; write it only
// while no transaction is in flight. A cell must be written before a query
// reads it.
// Throughput is one transaction per cycle while out_o is not stalled: the
// grid sits in four banks split by column and row parity, so all four corners
// are read in the same cycle. From acceptance to sample_value a query passes
// the position stages, the bank read register, then the edge and final blends.
// Writes travel the same pipe and reach the banks in order with queries.
// Reset clears the pipe valids and returns the registers to their defaults;
// grid contents are not cleared. When out_o stalls the whole pipe holds and
// in_i.ready drops; nothing is lost or repeated.
module staggered_grid_bilinear_sampler
  import sgbs_pkg::*;
#(
  parameter int unsigned MAX_COLS   = DEF_MAX_COLS,
  parameter int unsigned MAX_ROWS   = DEF_MAX_ROWS,
  parameter int unsigned VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  sgbs_in_if.sink    in_i,
  sgbs_cfg_if.sink   cfg_i,
  sgbs_out_if.source out_o
);

  localparam int unsigned CIW        = (MAX_COLS > 2) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned RIW        = (MAX_ROWS > 2) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CSW        = $clog2(MAX_COLS + 1);
  localparam int unsigned RSW        = $clog2(MAX_ROWS + 1);
  localparam int unsigned COLS_HALF  = (MAX_COLS + 1) / 2;
  localparam int unsigned ROWS_HALF  = (MAX_ROWS + 1) / 2;
  localparam int unsigned BANK_DEPTH = COLS_HALF * ROWS_HALF;
  localparam int unsigned AW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int unsigned STAGES     = 7;

  typedef logic [VALUE_BITS-1:0] value_t;

  // configuration registers
  logic [RECIP_W-1:0]    recip_w_q, recip_h_q;
  logic [FRAC_W-1:0]     offset_x_q, offset_y_q;
  logic [SIZE_REG_W-1:0] cols_q, rows_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recip_w_q  <= RECIP_RST;
      recip_h_q  <= RECIP_RST;
      offset_x_q <= OFFSET_RST;
      offset_y_q <= OFFSET_RST;
      cols_q     <= SIZE_RST;
      rows_q     <= SIZE_RST;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_RECIP_W:  recip_w_q  <= cfg_i.data[RECIP_W-1:0];
        REG_RECIP_H:  recip_h_q  <= cfg_i.data[RECIP_W-1:0];
        REG_OFFSET_X: offset_x_q <= cfg_i.data[FRAC_W-1:0];
        REG_OFFSET_Y: offset_y_q <= cfg_i.data[FRAC_W-1:0];
        REG_COLS:     cols_q     <= cfg_i.data[SIZE_REG_W-1:0];
        REG_ROWS:     rows_q     <= cfg_i.data[SIZE_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // sizes saturated to the grid range
  logic [CMP_W-1:0] cols_ext, rows_ext;
  logic [CSW-1:0]   cols_c;
  logic [RSW-1:0]   rows_c;

  always_comb begin
    cols_ext = CMP_W'(cols_q);
    rows_ext = CMP_W'(rows_q);
    if (cols_ext < CMP_W'(2)) cols_c = CSW'(2);
    else if (cols_ext > CMP_W'(MAX_COLS)) cols_c = CSW'(MAX_COLS);
    else cols_c = CSW'(cols_ext);
    if (rows_ext < CMP_W'(2)) rows_c = RSW'(2);
    else if (rows_ext > CMP_W'(MAX_ROWS)) rows_c = RSW'(MAX_ROWS);
    else rows_c = RSW'(rows_ext);
  end

  // pipeline control
  logic              en;
  logic [STAGES:1]   sv_q;
  logic [2:1]        wv_q;
  logic              in_fire, in_sample, in_write_ok;

  assign en          = !sv_q[STAGES] || out_o.ready;
  assign in_i.ready  = en;
  assign in_fire     = in_i.valid && en;
  assign in_sample   = (opcode_e'(in_i.opcode) == OP_SAMPLE);
  assign in_write_ok = (32'(in_i.cell_col) < MAX_COLS) && (32'(in_i.cell_row) < MAX_ROWS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q <= '0;
      wv_q <= '0;
    end else if (en) begin
      sv_q <= {sv_q[STAGES-1:1], in_fire && in_sample};
      wv_q <= {wv_q[1], in_fire && !in_sample && in_write_ok};
    end
  end

  // write transaction carried down to the bank stage
  logic [CELL_IDX_W-1:0] wcol_q [2:1];
  logic [CELL_IDX_W-1:0] wrow_q [2:1];
  value_t                wval_q [2:1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      wcol_q[1] <= in_i.cell_col;
      wrow_q[1] <= in_i.cell_row;
      wval_q[1] <= in_i.cell_value;
      wcol_q[2] <= wcol_q[1];
      wrow_q[2] <= wrow_q[1];
      wval_q[2] <= wval_q[1];
    end
  end

  // grid positions, two stages
  logic [CIW-1:0]    ci;
  logic [RIW-1:0]    cj;
  logic [FRAC_W-1:0] fx, fy;

  sgbs_locate #(.MAX_SIZE(MAX_COLS)) u_loc_x (
    .clk_i, .en_i(en), .point_i(in_i.point_x), .recip_i(recip_w_q),
    .offset_i(offset_x_q), .size_i(cols_c), .cell_o(ci), .frac_o(fx)
  );

  sgbs_locate #(.MAX_SIZE(MAX_ROWS)) u_loc_y (
    .clk_i, .en_i(en), .point_i(in_i.point_y), .recip_i(recip_h_q),
    .offset_i(offset_y_q), .size_i(rows_c), .cell_o(cj), .frac_o(fy)
  );

  // banked grid store, bank index is {row parity, column parity}
  logic [CIW:0]  ci_next;
  logic [RIW:0]  cj_next;
  logic [AW-1:0] raddr [4];
  logic [AW-1:0] waddr;
  logic [1:0]    wbank;
  value_t        rdata [4];
  logic [31:0]   colh, rowh;

  always_comb begin
    ci_next = (CIW+1)'(ci) + (CIW+1)'(1);
    cj_next = (RIW+1)'(cj) + (RIW+1)'(1);
    for (int b = 0; b < 4; b++) begin
      colh = (b[0] == ci[0]) ? (32'(ci) >> 1) : (32'(ci_next) >> 1);
      rowh = (b[1] == cj[0]) ? (32'(cj) >> 1) : (32'(cj_next) >> 1);
      raddr[b] = AW'(rowh * COLS_HALF + colh);
    end
    waddr = AW'((32'(wrow_q[2]) >> 1) * COLS_HALF + (32'(wcol_q[2]) >> 1));
    wbank = {wrow_q[2][0], wcol_q[2][0]};
  end

  for (genvar gb = 0; gb < 4; gb++) begin : g_bank
    sgbs_bank #(.DEPTH(BANK_DEPTH), .VALUE_BITS(VALUE_BITS)) u_bank (
      .clk_i, .en_i(en), .we_i(wv_q[2] && (wbank == 2'(gb))),
      .waddr_i(waddr), .wdata_i(wval_q[2]), .raddr_i(raddr[gb]), .rdata_o(rdata[gb])
    );
  end

  // side data for the blend stages
  logic              pi_q, pj_q;
  logic [FRAC_W-1:0] fx_q3, fy_q3, fy_q4, fy_q5;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pi_q  <= ci[0];
      pj_q  <= cj[0];
      fx_q3 <= fx;
      fy_q3 <= fy;
      fy_q4 <= fy_q3;
      fy_q5 <= fy_q4;
    end
  end

  logic signed [VALUE_BITS-1:0] c00, c10, c01, c11, lower, upper, result;

  always_comb begin
    c00 = rdata[{pj_q, pi_q}];
    c10 = rdata[{pj_q, !pi_q}];
    c01 = rdata[{!pj_q, pi_q}];
    c11 = rdata[{!pj_q, !pi_q}];
  end

  sgbs_lerp #(.VALUE_BITS(VALUE_BITS)) u_lerp_lo (
    .clk_i, .en_i(en), .a_i(c00), .b_i(c10), .f_i(fx_q3), .y_o(lower)
  );

  sgbs_lerp #(.VALUE_BITS(VALUE_BITS)) u_lerp_hi (
    .clk_i, .en_i(en), .a_i(c01), .b_i(c11), .f_i(fx_q3), .y_o(upper)
  );

  sgbs_lerp #(.VALUE_BITS(VALUE_BITS)) u_lerp_v (
    .clk_i, .en_i(en), .a_i(lower), .b_i(upper), .f_i(fy_q5), .y_o(result)
  );

  assign out_o.valid        = sv_q[STAGES];
  assign out_o.sample_value = result;

  // checks
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(sv_q) && $stable(wv_q))
    else $error("pipeline valids moved during a stall");

  a_write_or_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(sv_q[1] && wv_q[1]) && !(sv_q[2] && wv_q[2]))
    else $error("one stage holds both a write and a sample");

  a_cell_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sv_q[2] |-> (CSW'(ci) < cols_c - CSW'(1)) && (RSW'(cj) < rows_c - RSW'(1)))
    else $error("sample cell outside the grid in use");

endmodule

/* tb/staggered_grid_bilinear_sampler_tb.sv */
`timescale 1ns / 1ps
// testbench for the staggered grid bilinear sampler: predicts samples and checks each one
module staggered_grid_bilinear_sampler_tb;
  import sgbs_pkg::*;

  localparam int unsigned NCOLS = DEF_MAX_COLS;
  localparam int unsigned NROWS = DEF_MAX_ROWS;
  localparam int unsigned LIMIT_CYCLES = 400000;

  typedef struct packed {
    opcode_e     op;
    logic [7:0]  col;
    logic [7:0]  row;
    logic [31:0] value;
    logic [31:0] px;
    logic [31:0] py;
  } in_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  sgbs_in_if  in_ch ();
  sgbs_out_if out_ch ();
  sgbs_cfg_if cfg_ch ();

  staggered_grid_bilinear_sampler u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .cfg_i  (cfg_ch.sink),
    .out_o  (out_ch.source)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  logic signed [31:0] grid_mirror [NCOLS*NROWS];
  bit                 cell_written [NCOLS*NROWS];
  logic [23:0]        scale_x, scale_y;
  logic [16:0]        shift_x, shift_y;
  logic [8:0]         ncols_reg, nrows_reg;

  logic signed [31:0] sample_queue [$];
  in_item_t           tx_queue [$];
  int errors = 0;
  int cycles = 0;
  int hold_cycles = 0;
  int sent_count = 0;
  int taken_count = 0;
  bit in_taken = 1'b0;
  bit stall_random = 1'b1;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic logic [63:0] size_clip(input logic [8:0] n, input int unsigned maxn);
    if (n < 2) return 64'd2;
    if (n > maxn) return 64'(maxn);
    return 64'(n);
  endfunction

  function automatic void grid_locate(input logic [31:0] pt, input logic [23:0] rc,
                                      input logic [16:0] off, input logic [63:0] sz,
                                      output logic [63:0] cell_idx,
                                      output logic [63:0] frac);
    logic [63:0] pos, top;
    pos = ((64'(pt) * 64'(rc)) >> 16) + 64'(off);
    top = (sz - 1) << 16;
    if (pos > top) pos = top;
    cell_idx = pos >> 16;
    if (cell_idx >= sz - 1) cell_idx = cell_idx - 1;
    frac = pos - (cell_idx << 16);
  endfunction

  function automatic logic signed [63:0] lerp_q16(input logic signed [63:0] a,
                                                  input logic signed [63:0] b,
                                                  input logic [63:0] f);
    logic signed [63:0] s;
    s = a * $signed(64'd65536 - f) + b * $signed(f) + 64'sd32768;
    return s >>> 16;
  endfunction

  function automatic logic signed [63:0] cell_at(input logic [63:0] c, input logic [63:0] r);
    if (c >= NCOLS || r >= NROWS) return 64'sd0;
    return 64'(grid_mirror[r*NCOLS + c]);
  endfunction

  function automatic logic signed [31:0] predict_sample(input logic [31:0] px,
                                                        input logic [31:0] py);
    logic [63:0] ci, cj, fx, fy;
    logic signed [63:0] lo, hi;
    grid_locate(px, scale_x, shift_x, size_clip(ncols_reg, NCOLS), ci, fx);
    grid_locate(py, scale_y, shift_y, size_clip(nrows_reg, NROWS), cj, fy);
    lo = lerp_q16(cell_at(ci, cj), cell_at(ci + 1, cj), fx);
    hi = lerp_q16(cell_at(ci, cj + 1), cell_at(ci + 1, cj + 1), fx);
    return 32'(lerp_q16(lo, hi, fy));
  endfunction

  // every corner a query could touch under the current settings must be written
  function automatic bit corners_ready(input logic [31:0] px, input logic [31:0] py);
    logic [63:0] ci, cj, fx, fy;
    grid_locate(px, scale_x, shift_x, size_clip(ncols_reg, NCOLS), ci, fx);
    grid_locate(py, scale_y, shift_y, size_clip(nrows_reg, NROWS), cj, fy);
    return cell_written[cj*NCOLS+ci] && cell_written[cj*NCOLS+ci+1] &&
           cell_written[(cj+1)*NCOLS+ci] && cell_written[(cj+1)*NCOLS+ci+1];
  endfunction

  // hands one transaction to the input driver and waits until it is accepted
  task automatic send_item(input opcode_e op, input logic [7:0] col, input logic [7:0] row,
                           input logic [31:0] value, input logic [31:0] px,
                           input logic [31:0] py);
    in_item_t item;
    item = '{op, col, row, value, px, py};
    if (op == OP_WRITE) begin
      grid_mirror[row*NCOLS + col] = value;
      cell_written[row*NCOLS + col] = 1'b1;
    end else begin
      sample_queue = {sample_queue, predict_sample(px, py)};
    end
    tx_queue = {tx_queue, item};
    sent_count++;
    wait (taken_count == sent_count);
  endtask

  task automatic write_cell(input int c, input int r, input logic [31:0] v);
    send_item(OP_WRITE, 8'(c), 8'(r), v, $urandom, $urandom);
  endtask

  task automatic query_point(input logic [31:0] px, input logic [31:0] py);
    if (corners_ready(px, py))
      send_item(OP_SAMPLE, 8'($urandom), 8'($urandom), $urandom, px, py);
  endtask

  task automatic drain_results();
    while (sample_queue.size() != 0 || tx_queue.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_register(input cfg_reg_e idx, input logic [23:0] value);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    case (idx)
      REG_RECIP_W:  scale_x = value;
      REG_RECIP_H:  scale_y = value;
      REG_OFFSET_X: shift_x = value[16:0];
      REG_OFFSET_Y: shift_y = value[16:0];
      REG_COLS:     ncols_reg = value[8:0];
      default:      nrows_reg = value[8:0];
    endcase
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_geometry(input logic [23:0] rw, input logic [23:0] rh,
                              input logic [16:0] ox, input logic [16:0] oy,
                              input logic [8:0] nc, input logic [8:0] nr);
    drain_results();
    write_register(REG_RECIP_W, rw);
    write_register(REG_RECIP_H, rh);
    write_register(REG_OFFSET_X, 24'(ox));
    write_register(REG_OFFSET_Y, 24'(oy));
    write_register(REG_COLS, 24'(nc));
    write_register(REG_ROWS, 24'(nr));
  endtask

  // random point scaled so most land inside a grid of n cells at unit scale
  function automatic logic [31:0] pick_coord(input int n);
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1:       return 32'(0);
      default: return 32'($urandom_range(0, n * 65536));
    endcase
  endfunction

  task automatic random_gap();
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 6)) @(posedge clk_i);
  endtask

  task automatic test_directed_extremes();
    write_cell(0, 0, 32'h7fffffff);
    write_cell(1, 0, 32'h80000000);
    write_cell(0, 1, 32'hffffffff);
    write_cell(1, 1, 32'h00000001);
    write_cell(255, 255, 32'h80000000);
    write_cell(254, 255, 32'h7fffffff);
    write_cell(255, 254, 32'h12345678);
    write_cell(254, 254, 32'hedcba987);
    set_geometry(24'h010000, 24'h010000, 17'd0, 17'd0, 9'd2, 9'd2);
    query_point(32'd0, 32'd0);
    query_point(32'h00008000, 32'h00008000);
    query_point(32'hffffffff, 32'hffffffff);
    query_point(32'h00010000, 32'h00000000);
    set_geometry(24'h000001, 24'hffffff, 17'h10000, 17'h10000, 9'd0, 9'd1);
    query_point(32'hffffffff, 32'h00000000);
    query_point(32'h00000000, 32'hffffffff);
    set_geometry(24'hffffff, 24'hffffff, 17'd0, 17'd0, 9'd256, 9'd256);
    query_point(32'hffffffff, 32'hffffffff);
    query_point(32'h00000000, 32'h00000000);
    set_geometry(24'h010000, 24'h010000, 17'd0, 17'd0, 9'd511, 9'd300);
    query_point(32'hffffffff, 32'hffffffff);
    query_point(32'h00fe8000, 32'h00fe4000);
  endtask

  task automatic test_random_small_grid();
    int n;
    n = $urandom_range(2, 12);
    set_geometry(24'($urandom_range(32768, 131072)), 24'($urandom_range(32768, 131072)),
                 17'($urandom_range(0, 65536)), 17'($urandom_range(0, 65536)),
                 9'(n), 9'(n));
    for (int r = 0; r < n; r++)
      for (int c = 0; c < n; c++) begin
        write_cell(c, r, $urandom);
        random_gap();
      end
    for (int k = 0; k < 90; k++) begin
      if ($urandom_range(0, 9) == 0)
        write_cell($urandom_range(0, n - 1), $urandom_range(0, n - 1), $urandom);
      else
        query_point(pick_coord(n), pick_coord(n));
      random_gap();
    end
  endtask

  task automatic test_backpressure_fill();
    stall_random = 1'b0;
    hold_cycles = 60;
    for (int k = 0; k < 40; k++) query_point(pick_coord(4), pick_coord(4));
    stall_random = 1'b1;
    drain_results();
  endtask

  task automatic test_full_grid_edges();
    set_geometry(24'h010000, 24'h010000, 17'd0, 17'd0, 9'd256, 9'd256);
    for (int k = 0; k < 60; k++)
      query_point(32'($urandom_range(0, 2)) << 16 | 32'($urandom_range(0, 65535)),
                  32'($urandom_range(0, 2)) << 16 | 32'($urandom_range(0, 65535)));
    for (int k = 0; k < 40; k++)
      query_point(32'($urandom_range(253, 300)) << 16 | 32'($urandom_range(0, 65535)),
                  32'($urandom_range(253, 300)) << 16 | 32'($urandom_range(0, 65535)));
  endtask

  // input driver: presents the next queued transaction once the current one is taken
  always @(negedge clk_i) begin
    if (!in_ch.valid || in_taken) begin
      if (tx_queue.size() != 0) begin
        in_ch.valid      <= 1'b1;
        in_ch.opcode     <= tx_queue[0].op;
        in_ch.cell_col   <= tx_queue[0].col;
        in_ch.cell_row   <= tx_queue[0].row;
        in_ch.cell_value <= tx_queue[0].value;
        in_ch.point_x    <= tx_queue[0].px;
        in_ch.point_y    <= tx_queue[0].py;
        void'(tx_queue.pop_front());
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver: random stall pattern, plus a long hold when requested
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else if (stall_random) begin
      out_ch.ready <= ($urandom_range(0, 3) != 0);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    in_taken = rst_ni && in_ch.valid && in_ch.ready;
    if (in_taken) taken_count++;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (sample_queue.size() == 0) begin
        report_mismatch("unexpected transaction", out_ch.sample_value, 32'h0);
      end else begin
        if (out_ch.sample_value !== sample_queue[0])
          report_mismatch("sample_value", out_ch.sample_value, sample_queue[0]);
        void'(sample_queue.pop_front());
      end
    end
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout");
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_WRITE;
    in_ch.cell_col = '0;
    in_ch.cell_row = '0;
    in_ch.cell_value = '0;
    in_ch.point_x = '0;
    in_ch.point_y = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_RECIP_W;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    scale_x = 24'd65536;
    scale_y = 24'd65536;
    shift_x = '0;
    shift_y = '0;
    ncols_reg = 9'd256;
    nrows_reg = 9'd256;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);
    test_directed_extremes();
    for (int p = 0; p < 12; p++) test_random_small_grid();
    test_backpressure_fill();
    test_full_grid_edges();
    drain_results();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
